### rtl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the proper divisor sum block.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int PRIME_DEPTH = 8192;
  localparam int IDX_W       = $clog2(PRIME_DEPTH);
  localparam int CNT_W       = 14;
  localparam int PRIME_W     = 32;
  localparam int NUM_W       = 64;
  localparam int STEP_W      = $clog2(NUM_W);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_WAIT,
    S_SQ,
    S_CHECK,
    S_DIV,
    S_MPOW,
    S_MSIG,
    S_TAIL,
    S_MTAIL,
    S_OUT
  } state_t;

endpackage

### rtl/pds_ram.sv
// ----------------------------------------------------------------------------
// pds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/pds_alu.sv
// ----------------------------------------------------------------------------
// pds_alu
// Bit-serial unit: 64 by 32 divide with remainder, or 64 by 64 multiply
// modulo 2^64, one bit per cycle.
// ----------------------------------------------------------------------------
module pds_alu
  import pds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  alu_req_t           req,
  input  logic [NUM_W-1:0]   opa,
  input  logic [NUM_W-1:0]   opb,
  output logic               done,
  output logic [NUM_W-1:0]   quot,
  output logic [PRIME_W-1:0] rem,
  output logic [NUM_W-1:0]   prod
);

  logic               busy_r;
  logic               done_r;
  alu_op_t            op_r;
  logic [STEP_W-1:0]  cnt_r;
  logic [NUM_W-1:0]   x_r;
  logic [NUM_W-1:0]   m_r;
  logic [NUM_W-1:0]   acc_r;
  logic [PRIME_W-1:0] d_r;
  logic [PRIME_W-1:0] rem_r;
  logic [PRIME_W:0]   trial;
  logic               ge;

  assign trial = {rem_r, x_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        x_r    <= opa;
        m_r    <= (req.op == ALU_DIV) ? '0 : opb;
        acc_r  <= '0;
        d_r    <= opb[PRIME_W-1:0];
        rem_r  <= '0;
      end else if (busy_r) begin
        case (op_r)
          ALU_DIV: begin
            rem_r <= ge ? PRIME_W'(trial - {1'b0, d_r}) : trial[PRIME_W-1:0];
            m_r   <= {m_r[NUM_W-2:0], ge};
            x_r   <= x_r << 1;
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == STEP_W'(NUM_W - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          ALU_MUL: begin
            if (m_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else begin
              if (m_r[0]) begin
                acc_r <= acc_r + x_r;
              end
              x_r <= x_r << 1;
              m_r <= m_r >> 1;
            end
          end
          default: busy_r <= 1'b0;
        endcase
      end
    end
  end

  assign done = done_r;
  assign quot = m_r;
  assign rem  = rem_r;
  assign prod = acc_r;

endmodule

### rtl/proper_divisor_sum.sv
// ----------------------------------------------------------------------------
// proper_divisor_sum
// Sum of proper divisors of a 64-bit number by trial division.
// ----------------------------------------------------------------------------
// Input channel in_*: in_tuser is the request kind (0 load, 1 query). A load
// item writes one prime table entry and gives no result. A query
// item gives exactly one result item on out_* with sigma(n) - n mod 2^64.
// cfg_we/cfg_wdata set prime_count, the most table entries walked, capped at 8192.
// A query walks the table one prime at a time through a shared bit-serial
// unit: each prime costs a fetch/square/compare, and each prime that is not
// skipped and does not end the walk a divide; each factor stripped costs a
// multiply and another divide, and each dividing prime and a leftover
// cofactor a multiply. in_tready is low for the whole query.
// The prime table is a single-port-write, registered-read RAM whose content
// is undefined after reset; reset clears prime_count and all control. A
// finished result sits in an output register; a new item is taken while it
// waits, and a second result waits in the block until the receiver takes
// the first.
// ----------------------------------------------------------------------------
module proper_divisor_sum
  import pds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [111:0]       in_tdata,   // table_index, prime_value, query_number, pad
  input  logic               in_tuser,   // req_type
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [NUM_W-1:0]   out_tdata   // divisor_sum
);

  state_t             state_r;
  state_t             state_nxt;
  logic [CNT_W-1:0]   prime_count_r;
  logic [CNT_W-1:0]   used_r;
  logic [CNT_W-1:0]   idx_r;
  logic [NUM_W-1:0]   n_r;
  logic [NUM_W-1:0]   rest_r;
  logic [NUM_W-1:0]   sigma_r;
  logic [NUM_W-1:0]   term_r;
  logic [NUM_W-1:0]   power_r;
  logic [NUM_W-1:0]   res_r;
  logic [PRIME_W-1:0] p_r;
  logic [NUM_W-1:0]   pp_r;
  logic               strip_r;
  logic               out_valid_r;
  logic [NUM_W-1:0]   out_data_r;

  logic [IDX_W-1:0]   in_index;
  logic [PRIME_W-1:0] in_prime;
  logic [NUM_W-1:0]   in_number;
  logic               in_fire;
  logic               ram_we;
  logic               ram_re;
  logic [PRIME_W-1:0] ram_rdata;
  alu_req_t           alu_req;
  logic [NUM_W-1:0]   alu_a;
  logic [NUM_W-1:0]   alu_b;
  logic               alu_done;
  logic [NUM_W-1:0]   alu_quot;
  logic [PRIME_W-1:0] alu_rem;
  logic [NUM_W-1:0]   alu_prod;
  logic               out_free;

  assign in_index  = in_tdata[IDX_W-1:0];
  assign in_prime  = in_tdata[IDX_W+PRIME_W-1:IDX_W];
  assign in_number = in_tdata[IDX_W+PRIME_W+NUM_W-1:IDX_W+PRIME_W];
  assign in_fire   = in_tvalid && in_tready;
  assign ram_we    = in_fire && (in_tuser == REQ_LOAD);
  assign out_free  = !out_valid_r || out_tready;

  pds_ram #(
    .WIDTH (PRIME_W),
    .DEPTH (PRIME_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_index),
    .wdata (in_prime),
    .re    (ram_re),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  pds_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_a),
    .opb   (alu_b),
    .done  (alu_done),
    .quot  (alu_quot),
    .rem   (alu_rem),
    .prod  (alu_prod)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_tuser == REQ_QUERY) begin
          state_nxt = (in_number < NUM_W'(2)) ? S_OUT : S_FETCH;
        end
      end
      S_FETCH: state_nxt = (idx_r == used_r) ? S_TAIL : S_WAIT;
      S_WAIT:  state_nxt = S_SQ;
      S_SQ:    state_nxt = S_CHECK;
      S_CHECK: begin
        if (p_r < PRIME_W'(2)) begin
          state_nxt = S_FETCH;
        end else if (pp_r > rest_r) begin
          state_nxt = S_TAIL;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (alu_done) begin
          if (alu_rem == '0) begin
            state_nxt = S_MPOW;
          end else if (strip_r) begin
            state_nxt = S_MSIG;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_MPOW:  if (alu_done) state_nxt = S_DIV;
      S_MSIG:  if (alu_done) state_nxt = S_FETCH;
      S_TAIL:  state_nxt = (rest_r > NUM_W'(1)) ? S_MTAIL : S_OUT;
      S_MTAIL: if (alu_done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready     = 1'b0;
    ram_re        = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_DIV;
    alu_a         = rest_r;
    alu_b         = {{(NUM_W-PRIME_W){1'b0}}, p_r};
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_FETCH: ram_re = (idx_r != used_r);
      S_CHECK: alu_req.start = (p_r >= PRIME_W'(2)) && (pp_r <= rest_r);
      S_DIV: begin
        if (alu_done) begin
          alu_req.op = ALU_MUL;
          if (alu_rem == '0) begin
            alu_req.start = 1'b1;
            alu_a = strip_r ? power_r : NUM_W'(1);
          end else if (strip_r) begin
            alu_req.start = 1'b1;
            alu_a = sigma_r;
            alu_b = term_r;
          end
        end
      end
      S_MPOW: begin
        // divide the new cofactor by the same prime
        alu_req.start = alu_done;
      end
      S_TAIL: begin
        alu_req.start = rest_r > NUM_W'(1);
        alu_req.op    = ALU_MUL;
        alu_a         = sigma_r;
        alu_b         = rest_r + NUM_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      prime_count_r <= '0;
      out_valid_r   <= 1'b0;
      strip_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        prime_count_r <= cfg_wdata;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire && in_tuser == REQ_QUERY) begin
            n_r     <= in_number;
            rest_r  <= in_number;
            sigma_r <= NUM_W'(1);
            idx_r   <= '0;
            res_r   <= '0;
            strip_r <= 1'b0;
            used_r  <= (prime_count_r > CNT_W'(PRIME_DEPTH)) ?
                       CNT_W'(PRIME_DEPTH) : prime_count_r;
          end
        end
        S_WAIT: p_r  <= ram_rdata;
        S_SQ:   pp_r <= p_r * p_r;
        S_CHECK: begin
          if (p_r < PRIME_W'(2)) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DIV: begin
          if (alu_done) begin
            if (alu_rem == '0) begin
              rest_r <= alu_quot;
              if (!strip_r) begin
                strip_r <= 1'b1;
                term_r  <= NUM_W'(1);
                power_r <= NUM_W'(1);
              end
            end else if (!strip_r) begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_MPOW: begin
          if (alu_done) begin
            power_r <= alu_prod;
            term_r  <= term_r + alu_prod;
          end
        end
        S_MSIG: begin
          if (alu_done) begin
            sigma_r <= alu_prod;
            strip_r <= 1'b0;
            idx_r   <= idx_r + 1'b1;
          end
        end
        S_TAIL: begin
          if (rest_r <= NUM_W'(1)) begin
            res_r <= sigma_r - n_r;
          end
        end
        S_MTAIL: begin
          if (alu_done) begin
            res_r <= alu_prod - n_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
